// ===== rtl/core/mtt_pkg.sv =====
// ----------------------------------------------------------------------------
// mtt_pkg
// Shared types and codes for the timer table: entry layout, result layout,
// operation and result-kind codes.
// ----------------------------------------------------------------------------
`default_nettype none
package mtt_pkg;

  localparam int TIME_W = 25;
  localparam int IN_TIME_W = 24;
  localparam int ID_W = 16;
  localparam int EV_W = 8;
  localparam int PRI_W = 3;
  localparam int PERIOD_W = 16;
  localparam int MAX_RES = 16;
  localparam int NRES_W = 5;

  localparam logic [1:0] OP_TICK = 2'd0;
  localparam logic [1:0] OP_ONESHOT = 2'd1;
  localparam logic [1:0] OP_PERIODIC = 2'd2;
  localparam logic [1:0] OP_CANCEL = 2'd3;

  localparam logic [1:0] KIND_CREATE = 2'd0;
  localparam logic [1:0] KIND_CANCEL = 2'd1;
  localparam logic [1:0] KIND_EXPIRY = 2'd2;

  localparam logic [1:0] CFG_PERIOD = 2'd0;
  localparam logic [1:0] CFG_RUNNING = 2'd1;

  typedef struct packed {
    logic [TIME_W-1:0] rem;
    logic [TIME_W-1:0] rel;
    logic [ID_W-1:0]   id;
    logic [EV_W-1:0]   ev;
    logic [PRI_W-1:0]  pri;
    logic              cb;
  } entry_t;

  typedef struct packed {
    logic shift;
    logic load;
  } cell_ctl_t;

  typedef struct packed {
    logic [1:0]       kind;
    logic             status;
    logic [ID_W-1:0]  id;
    logic [EV_W-1:0]  ev;
    logic [PRI_W-1:0] pri;
    logic             per;
    logic             cb;
    logic             last;
  } res_t;

endpackage
`default_nettype wire

// ===== rtl/core/mtt_cell.sv =====
// ----------------------------------------------------------------------------
// mtt_cell
// One table slot: takes its neighbor's entry on shift, or a new entry on load.
// ----------------------------------------------------------------------------
`default_nettype none
module mtt_cell
  import mtt_pkg::*;
(
  input  wire logic      clk,
  input  wire cell_ctl_t ctl,
  input  wire entry_t    nbr_i,
  input  wire entry_t    load_i,
  output entry_t         q_o
);

  entry_t q_r;

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      q_r <= load_i;
    end else if (ctl.shift) begin
      q_r <= nbr_i;
    end
  end

  assign q_o = q_r;

endmodule
`default_nettype wire

// ===== rtl/core/mtt_rem.sv =====
// ----------------------------------------------------------------------------
// mtt_rem
// Restoring remainder unit: one dividend bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none
module mtt_rem
  import mtt_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 start,
  input  wire logic [IN_TIME_W-1:0] dividend,
  input  wire logic [PERIOD_W-1:0]  divisor,
  output logic                      done,
  output logic [PERIOD_W-1:0]       rem
);

  logic [IN_TIME_W-1:0] dvd_r;
  logic [PERIOD_W-1:0]  dvs_r;
  logic [PERIOD_W:0]    rem_r;
  logic [4:0]           cnt_r;
  logic                 busy_r;
  logic                 done_r;
  logic [PERIOD_W:0]    trial;

  always_comb begin
    trial = {rem_r[PERIOD_W-1:0], dvd_r[IN_TIME_W-1]};
    if (trial >= {1'b0, dvs_r}) begin
      trial = trial - {1'b0, dvs_r};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
        dvd_r  <= dividend;
        dvs_r  <= divisor;
        rem_r  <= '0;
      end else if (busy_r) begin
        rem_r <= trial;
        dvd_r <= {dvd_r[IN_TIME_W-2:0], 1'b0};
        cnt_r <= cnt_r + 5'd1;
        if (cnt_r == 5'(IN_TIME_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign rem  = rem_r[PERIOD_W-1:0];

endmodule
`default_nettype wire

// ===== rtl/core/multi_timer_table_top.sv =====
// ----------------------------------------------------------------------------
// multi_timer_table_top
// Ordered table of one-shot and periodic timers held in a ring of cells.
// ----------------------------------------------------------------------------
// A tick rotates the whole ring once past one shared update stage and reports
// expiries in table order, at most one per cycle. A cancel rotates the ring once
// to search and, if the timer is found, closes the gap in a compaction state. A
// create waits on the remainder unit; a create into a full table is refused
// straight from idle. A paused tick returns at once. Results are strobed on
// out_valid for one cycle each and cannot be held off.
`default_nettype none
module multi_timer_table_top
  import mtt_pkg::*;
#(
  parameter int MAX_TIMERS = 16,
  parameter int FIRST_ONESHOT_ID = 16
)(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 start,
  output logic                      busy,
  input  wire logic [1:0]           in_op,
  input  wire logic [IN_TIME_W-1:0] in_time_ms,
  input  wire logic [ID_W-1:0]      in_timer_id,
  input  wire logic [EV_W-1:0]      in_event_code,
  input  wire logic [PRI_W-1:0]     in_priority_req,
  input  wire logic                 in_has_callback,
  output logic                      out_valid,
  output logic [1:0]                out_result_kind,
  output logic                      out_status,
  output logic [ID_W-1:0]           out_id,
  output logic [EV_W-1:0]           out_event,
  output logic [PRI_W-1:0]          out_priority,
  output logic                      out_periodic_source,
  output logic                      out_via_callback,
  output logic                      out_last,
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [1:0]           cfg_index,
  input  wire logic [PERIOD_W-1:0]  cfg_data
);

  localparam int CW = $clog2(MAX_TIMERS + 1);

  localparam logic [2:0] ST_IDLE    = 3'd0;
  localparam logic [2:0] ST_TICK    = 3'd1;
  localparam logic [2:0] ST_TFLUSH  = 3'd2;
  localparam logic [2:0] ST_DIV     = 3'd3;
  localparam logic [2:0] ST_CANCEL  = 3'd4;
  localparam logic [2:0] ST_COMPACT = 3'd5;

  logic [2:0]           state_r, state_nxt;
  logic [PERIOD_W-1:0]  period_r;
  logic                 running_r;
  logic [CW-1:0]        count_r, count_nxt;
  logic [ID_W-1:0]      next_id_r, next_id_nxt;
  logic [CW-1:0]        step_r, step_nxt;
  logic [CW-1:0]        idx_r, idx_nxt;
  logic                 found_r, found_nxt;
  logic [NRES_W-1:0]    nres_r, nres_nxt;
  logic                 pend_v_r, pend_v_nxt;
  res_t                 pend_r, pend_nxt;
  logic [1:0]           op_r;
  logic [IN_TIME_W-1:0] time_r;
  logic [ID_W-1:0]      tid_r;
  logic [EV_W-1:0]      ev_r;
  logic [PRI_W-1:0]     pri_r;
  logic                 cb_r;
  logic                 out_valid_r;
  res_t                 out_r;

  logic                 emit_v;
  res_t                 emit_d;
  logic                 rot_en, compact_en, create_wr, div_start, div_done;
  logic [PERIOD_W-1:0]  div_rem;
  entry_t               q [MAX_TIMERS];
  entry_t               tail, new_ent, head;
  logic [TIME_W-1:0]    p25, sub, rt;
  logic                 hv, expire, last_step;

  assign cfg_ready = 1'b1;
  assign busy = (state_r != ST_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      period_r  <= PERIOD_W'(1);
      running_r <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_PERIOD:  period_r <= cfg_data;
        CFG_RUNNING: running_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // div_start rises with the accepted request, so take the time off the port
  mtt_rem u_rem (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (in_time_ms),
    .divisor  (period_r),
    .done     (div_done),
    .rem      (div_rem)
  );

  // Head update shared by the whole ring during a tick
  assign head = q[0];
  assign p25 = {{(TIME_W-PERIOD_W){1'b0}}, period_r};
  assign hv = ({1'b0, step_r} < {1'b0, count_r});
  assign sub = (head.rem > p25) ? head.rem - p25 : '0;
  assign expire = (state_r == ST_TICK) && hv && (head.rem != '0) && (sub < p25);
  assign last_step = (step_r == CW'(MAX_TIMERS - 1));

  always_comb begin
    tail = head;
    if (state_r == ST_TICK && hv && head.rem != '0) begin
      tail.rem = expire ? head.rel : sub;
    end
  end

  // Round up to the tick period
  always_comb begin
    rt = {1'b0, time_r};
    if (period_r != '0 && div_rem != '0) begin
      rt = {1'b0, time_r} + p25 - {{(TIME_W-PERIOD_W){1'b0}}, div_rem};
    end
    new_ent.rem = rt;
    new_ent.rel = (op_r == OP_PERIODIC) ? rt : '0;
    new_ent.id  = (op_r == OP_PERIODIC) ? tid_r : next_id_r;
    new_ent.ev  = ev_r;
    new_ent.pri = pri_r;
    new_ent.cb  = cb_r;
  end

  for (genvar k = 0; k < MAX_TIMERS; k++) begin : g_cell
    cell_ctl_t ctl;
    entry_t    nbr;
    assign ctl.shift = rot_en || (compact_en && (idx_r <= CW'(k)));
    assign ctl.load  = create_wr && (count_r == CW'(k));
    if (k == MAX_TIMERS - 1) begin : g_tail
      assign nbr = tail;
    end else begin : g_mid
      assign nbr = q[k+1];
    end
    mtt_cell u_cell (
      .clk    (clk),
      .ctl    (ctl),
      .nbr_i  (nbr),
      .load_i (new_ent),
      .q_o    (q[k])
    );
  end

  always_comb begin
    state_nxt   = state_r;
    count_nxt   = count_r;
    next_id_nxt = next_id_r;
    step_nxt    = step_r;
    idx_nxt     = idx_r;
    found_nxt   = found_r;
    nres_nxt    = nres_r;
    pend_v_nxt  = pend_v_r;
    pend_nxt    = pend_r;
    emit_v      = 1'b0;
    emit_d      = '0;
    rot_en      = 1'b0;
    compact_en  = 1'b0;
    create_wr   = 1'b0;
    div_start   = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          step_nxt = '0;
          case (in_op)
            OP_TICK: begin
              if (running_r && period_r != '0) begin
                state_nxt  = ST_TICK;
                nres_nxt   = '0;
                pend_v_nxt = 1'b0;
              end
            end
            OP_ONESHOT, OP_PERIODIC: begin
              if (count_r >= CW'(MAX_TIMERS)) begin
                emit_v        = 1'b1;
                emit_d.kind   = KIND_CREATE;
                emit_d.status = 1'b1;
                emit_d.per    = (in_op == OP_PERIODIC);
                emit_d.last   = 1'b1;
              end else begin
                state_nxt = ST_DIV;
                div_start = 1'b1;
              end
            end
            default: begin
              state_nxt = ST_CANCEL;
              found_nxt = 1'b0;
            end
          endcase
        end
      end
      ST_TICK: begin
        rot_en = 1'b1;
        if (expire && nres_r < NRES_W'(MAX_RES)) begin
          if (pend_v_r) begin
            emit_v = 1'b1;
            emit_d = pend_r;
          end
          pend_v_nxt      = 1'b1;
          pend_nxt.kind   = KIND_EXPIRY;
          pend_nxt.status = 1'b0;
          pend_nxt.id     = head.id;
          pend_nxt.ev     = head.ev;
          pend_nxt.pri    = head.pri;
          pend_nxt.per    = (head.rel != '0);
          pend_nxt.cb     = head.cb;
          pend_nxt.last   = 1'b0;
          nres_nxt        = nres_r + NRES_W'(1);
        end
        step_nxt = step_r + CW'(1);
        if (last_step) begin
          state_nxt = ST_TFLUSH;
        end
      end
      ST_TFLUSH: begin
        // flag the held-back expiry as final
        if (pend_v_r) begin
          emit_v      = 1'b1;
          emit_d      = pend_r;
          emit_d.last = 1'b1;
        end
        pend_v_nxt = 1'b0;
        state_nxt  = ST_IDLE;
      end
      ST_DIV: begin
        if (div_done) begin
          create_wr     = 1'b1;
          count_nxt     = count_r + CW'(1);
          emit_v        = 1'b1;
          emit_d.kind   = KIND_CREATE;
          emit_d.id     = new_ent.id;
          emit_d.per    = (op_r == OP_PERIODIC);
          emit_d.last   = 1'b1;
          if (op_r != OP_PERIODIC) begin
            next_id_nxt = next_id_r + ID_W'(1);
          end
          state_nxt = ST_IDLE;
        end
      end
      ST_CANCEL: begin
        rot_en = 1'b1;
        if (!found_r && hv && head.id == tid_r) begin
          found_nxt = 1'b1;
          idx_nxt   = step_r;
        end
        step_nxt = step_r + CW'(1);
        if (last_step) begin
          if (found_nxt) begin
            state_nxt = ST_COMPACT;
          end else begin
            emit_v        = 1'b1;
            emit_d.kind   = KIND_CANCEL;
            emit_d.status = 1'b1;
            emit_d.id     = tid_r;
            emit_d.last   = 1'b1;
            state_nxt     = ST_IDLE;
          end
        end
      end
      ST_COMPACT: begin
        // close the gap left by the removed entry
        compact_en  = 1'b1;
        count_nxt   = count_r - CW'(1);
        emit_v      = 1'b1;
        emit_d.kind = KIND_CANCEL;
        emit_d.id   = tid_r;
        emit_d.last = 1'b1;
        state_nxt   = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      next_id_r   <= ID_W'(FIRST_ONESHOT_ID);
      step_r      <= '0;
      found_r     <= 1'b0;
      nres_r      <= '0;
      pend_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      next_id_r   <= next_id_nxt;
      step_r      <= step_nxt;
      found_r     <= found_nxt;
      nres_r      <= nres_nxt;
      pend_v_r    <= pend_v_nxt;
      out_valid_r <= emit_v;
    end
  end

  always_ff @(posedge clk) begin
    idx_r  <= idx_nxt;
    pend_r <= pend_nxt;
    out_r  <= emit_d;
    if (start && !busy) begin
      op_r   <= in_op;
      time_r <= in_time_ms;
      tid_r  <= in_timer_id;
      ev_r   <= in_event_code;
      pri_r  <= in_priority_req;
      cb_r   <= in_has_callback;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_result_kind     = out_r.kind;
  assign out_status          = out_r.status;
  assign out_id              = out_r.id;
  assign out_event           = out_r.ev;
  assign out_priority        = out_r.pri;
  assign out_periodic_source = out_r.per;
  assign out_via_callback    = out_r.cb;
  assign out_last            = out_r.last;

endmodule
`default_nettype wire

// ===== dv/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the timer table: drives create, cancel and tick
// requests under several period and run settings, predicts every answer and
// expiry, and compares each strobed result against the oldest prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

typedef struct packed {
  logic [1:0]  kind;
  logic        status;
  logic [15:0] id;
  logic [7:0]  ev;
  logic [2:0]  pri;
  logic        per;
  logic        cb;
  logic        last;
} timer_result_t;

class timer_scoreboard;
  int unsigned period;
  bit          run;
  logic [24:0] rem_q [16];
  logic [24:0] rel_q [16];
  logic [15:0] id_q  [16];
  logic [7:0]  ev_q  [16];
  logic [2:0]  pri_q [16];
  logic        cb_q  [16];
  int          count;
  logic [15:0] next_id;
  timer_result_t pending [$];
  int          errors;
  int          checked;

  function new();
    period = 1;
    run = 0;
    count = 0;
    next_id = 16'd16;
    errors = 0;
    checked = 0;
  endfunction

  function void note_request(logic [1:0] op, logic [23:0] t, logic [15:0] tid,
                             logic [7:0] ev, logic [2:0] pri, logic cb);
    int unsigned r;
    int unsigned rt;
    int n;
    int found;
    timer_result_t res;
    n = 0;
    found = -1;
    res = '0;
    if (op == mtt_pkg::OP_TICK) begin
      if (!run || period == 0) return;
      for (int i = 0; i < count; i++) begin
        r = rem_q[i];
        if (r == 0) continue;
        r = (r > period) ? r - period : 0;
        if (r < period) begin
          res = '0;
          res.kind = mtt_pkg::KIND_EXPIRY;
          res.id = id_q[i];
          res.ev = ev_q[i];
          res.pri = pri_q[i];
          res.per = (rel_q[i] != 0);
          res.cb = cb_q[i];
          pending = {pending, res};
          n++;
          r = rel_q[i];
        end
        rem_q[i] = r[24:0];
      end
      if (n > 0) pending[$].last = 1'b1;
      return;
    end
    res.last = 1'b1;
    if (op == mtt_pkg::OP_ONESHOT || op == mtt_pkg::OP_PERIODIC) begin
      res.kind = mtt_pkg::KIND_CREATE;
      res.per = (op == mtt_pkg::OP_PERIODIC);
      if (count >= 16) begin
        res.status = 1'b1;
      end else begin
        rt = t;
        if (period != 0 && (rt % period) != 0) rt = rt + period - (rt % period);
        rt = rt & 32'h1FFFFFF;
        if (res.per) res.id = tid;
        else begin
          res.id = next_id;
          next_id = next_id + 16'd1;
        end
        rem_q[count] = rt[24:0];
        rel_q[count] = res.per ? rt[24:0] : 25'd0;
        id_q[count] = res.id;
        ev_q[count] = ev;
        pri_q[count] = pri;
        cb_q[count] = cb;
        count++;
      end
    end else begin
      res.kind = mtt_pkg::KIND_CANCEL;
      res.id = tid;
      for (int i = 0; i < count; i++)
        if (found < 0 && id_q[i] == tid) found = i;
      if (found < 0) res.status = 1'b1;
      else begin
        for (int j = found; j + 1 < count; j++) begin
          rem_q[j] = rem_q[j+1];
          rel_q[j] = rel_q[j+1];
          id_q[j] = id_q[j+1];
          ev_q[j] = ev_q[j+1];
          pri_q[j] = pri_q[j+1];
          cb_q[j] = cb_q[j+1];
        end
        count--;
      end
    end
    pending = {pending, res};
  endfunction

  function void check_result(timer_result_t got);
    timer_result_t want;
    if (pending.size() == 0) begin
      $error("result with no request outstanding: id %0d", got.id);
      errors++;
      return;
    end
    want = pending.pop_front();
    checked++;
    if (got.kind != want.kind) begin
      $error("result_kind expected %0d got %0d", want.kind, got.kind); errors++;
    end
    if (got.status != want.status) begin
      $error("status expected %0d got %0d", want.status, got.status); errors++;
    end
    if (got.id != want.id) begin
      $error("out_id expected %0d got %0d", want.id, got.id); errors++;
    end
    if (got.ev != want.ev) begin
      $error("out_event expected %0d got %0d", want.ev, got.ev); errors++;
    end
    if (got.pri != want.pri) begin
      $error("out_priority expected %0d got %0d", want.pri, got.pri); errors++;
    end
    if (got.per != want.per) begin
      $error("periodic_source expected %0d got %0d", want.per, got.per); errors++;
    end
    if (got.cb != want.cb) begin
      $error("via_callback expected %0d got %0d", want.cb, got.cb); errors++;
    end
    if (got.last != want.last) begin
      $error("last expected %0d got %0d", want.last, got.last); errors++;
    end
  endfunction
endclass

module tb;
  import mtt_pkg::*;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [1:0] in_op = '0;
  logic [IN_TIME_W-1:0] in_time_ms = '0;
  logic [ID_W-1:0] in_timer_id = '0;
  logic [EV_W-1:0] in_event_code = '0;
  logic [PRI_W-1:0] in_priority_req = '0;
  logic in_has_callback = 1'b0;
  logic out_valid;
  logic [1:0] out_result_kind;
  logic out_status;
  logic [ID_W-1:0] out_id;
  logic [EV_W-1:0] out_event;
  logic [PRI_W-1:0] out_priority;
  logic out_periodic_source;
  logic out_via_callback;
  logic out_last;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [1:0] cfg_index = '0;
  logic [PERIOD_W-1:0] cfg_data = '0;

  timer_scoreboard timers = new();
  int unsigned cycles = 0;
  int unsigned requests = 0;
  bit quiet_phase = 0;
  localparam int unsigned CYCLE_LIMIT = 400000;

  multi_timer_table_top uut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("multi_timer_table_top verification failed");
      $finish;
    end
  end

  // sample results at the edge that ends the strobe cycle
  always @(posedge clk) begin
    if (rst_n && out_valid)
      timers.check_result({out_result_kind, out_status, out_id, out_event,
                           out_priority, out_periodic_source, out_via_callback,
                           out_last});
  end

  // drop start before any idle time so a request is never taken twice
  task automatic idle_gap();
    if (!quiet_phase && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
  endtask

  task automatic send_request(logic [1:0] op, logic [23:0] t, logic [15:0] tid,
                              logic [7:0] ev, logic [2:0] pri, logic cb);
    idle_gap();
    start <= 1'b1;
    in_op <= op;
    in_time_ms <= t;
    in_timer_id <= tid;
    in_event_code <= ev;
    in_priority_req <= pri;
    in_has_callback <= cb;
    @(posedge clk);
    while (busy) @(posedge clk);
    timers.note_request(op, t, tid, ev, pri, cb);
    requests++;
  endtask

  // hold until drained, then allow the slowest operation to finish
  task automatic drain();
    start <= 1'b0;
    while (timers.pending.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [15:0] value);
    drain();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    if (idx == CFG_PERIOD) timers.period = value;
    else timers.run = value[0];
  endtask

  task automatic random_request(int unsigned per_max);
    logic [1:0] op;
    logic [23:0] t;
    logic [15:0] tid;
    int unsigned sel;
    sel = $urandom_range(0, 99);
    if (sel < 45) op = OP_TICK;
    else if (sel < 65) op = OP_ONESHOT;
    else if (sel < 80) op = OP_PERIODIC;
    else op = OP_CANCEL;
    t = ($urandom_range(0, 9) == 0) ? 24'($urandom) : 24'($urandom_range(0, per_max));
    tid = 16'($urandom_range(0, 40));
    if ($urandom_range(0, 9) == 0) tid = 16'($urandom);
    if (op == OP_CANCEL && timers.count > 0 && $urandom_range(0, 3) != 0)
      tid = timers.id_q[$urandom_range(0, timers.count - 1)];
    send_request(op, t, tid, 8'($urandom), 3'($urandom), 1'($urandom));
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: paused tick, extremes, full table, not found cancel
    send_request(OP_TICK, 24'd0, 16'd0, 8'd0, 3'd0, 1'b0);
    send_request(OP_ONESHOT, 24'd0, 16'd0, 8'hFF, 3'd7, 1'b1);
    send_request(OP_PERIODIC, 24'hFFFFFF, 16'hFFFF, 8'h00, 3'd0, 1'b0);
    send_request(OP_CANCEL, 24'd0, 16'h1234, 8'd0, 3'd0, 1'b0);
    send_request(OP_CANCEL, 24'd0, 16'hFFFF, 8'd0, 3'd0, 1'b0);
    write_reg(CFG_PERIOD, 16'hFFFF);
    write_reg(CFG_RUNNING, 16'd1);
    for (int i = 0; i < 16; i++)
      send_request(i[0] ? OP_PERIODIC : OP_ONESHOT, 24'($urandom_range(1, 200000)),
                   16'(i), 8'(i), 3'(i), i[1]);
    send_request(OP_ONESHOT, 24'd5, 16'd0, 8'd1, 3'd1, 1'b0);
    send_request(OP_TICK, 24'd0, 16'd0, 8'd0, 3'd0, 1'b0);
    send_request(OP_TICK, 24'd0, 16'd0, 8'd0, 3'd0, 1'b0);
    write_reg(CFG_PERIOD, 16'd0);
    send_request(OP_TICK, 24'd0, 16'd0, 8'd0, 3'd0, 1'b0);
    for (int i = 0; i < 16; i++)
      send_request(OP_CANCEL, 24'd0, timers.id_q[0], 8'd0, 3'd0, 1'b0);
    send_request(OP_ONESHOT, 24'd7, 16'd0, 8'd2, 3'd2, 1'b1);

    // random phases over a spread of period and run settings
    for (int ph = 0; ph < 8; ph++) begin
      int unsigned p;
      case (ph)
        0: p = 1;
        1: p = 3;
        2: p = 0;
        3: p = 65535;
        default: p = $urandom_range(1, 50);
      endcase
      write_reg(CFG_PERIOD, 16'(p));
      write_reg(CFG_RUNNING, (ph == 5) ? 16'd0 : 16'd1);
      if (ph == 7) quiet_phase = 1;
      repeat (50) random_request((p == 0 ? 20 : p) * 8);
    end

    drain();
    $display("covered %0d requests and %0d checked results over eight settings",
             requests, timers.checked);
    if (timers.errors == 0 && timers.pending.size() == 0)
      $display("multi_timer_table_top verification clean");
    else
      $display("multi_timer_table_top verification failed");
    $finish;
  end
endmodule

// ===== filelist.f =====
rtl/core/mtt_pkg.sv
rtl/core/mtt_cell.sv
rtl/core/mtt_rem.sv
rtl/core/multi_timer_table_top.sv
dv/tb.sv
